FILE: rtl/core/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types, constants and the row setup step table of the perspective
// plane texture mapper.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int TEX_SIDE_BITS_DEF = 8;
  localparam int VEC_W      = 48;
  localparam int ACC_W      = 48;
  localparam int OPA_W      = 33;
  localparam int OPB_W      = 16;
  localparam int COORD_W    = 32;
  localparam int NUM_STEPS  = 27;
  localparam int STEP_W     = 5;
  localparam int FRAC_BITS  = 24;
  localparam int DIV_STEPS  = ACC_W + FRAC_BITS;
  localparam int DIV_CNT_W  = 7;
  localparam int NUM_ACC    = 12;
  localparam int NUM_COMP   = 9;
  localparam int PADDR_W    = 6;
  localparam int PDATA_W    = 64;

  localparam logic [9:0]  DIST_RST   = 10'd240;
  localparam logic [9:0]  COL_RST    = 10'h35f;  // -161
  localparam logic [7:0]  CENTRE_RST = 8'd100;
  localparam logic [23:0] NEAR_RST   = 24'd65536;

  typedef enum logic [2:0] {
    REG_ORIGIN = 3'd0,
    REG_AXIS_U = 3'd1,
    REG_AXIS_V = 3'd2,
    REG_DIST   = 3'd3,
    REG_COL    = 3'd4,
    REG_CENTRE = 3'd5,
    REG_NEAR   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_ROW   = 2'd1,
    FUNC_PIXEL = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DEN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } setup_state_t;

  // Operand A: 0..8 plane components, 9..17 accumulated cross terms.
  // Operand B: 0..8 plane components, 9 distance, 10 row offset, 11 column.
  typedef struct packed {
    logic [4:0] a_sel;
    logic [3:0] b_sel;
    logic [3:0] dest;
    logic       sub;
    logic       first;
  } step_t;

  typedef struct packed {
    logic                 busy;
    logic                 load;
    logic [COORD_W-1:0]   u;
    logic [COORD_W-1:0]   v;
    logic [COORD_W-1:0]   du;
    logic [COORD_W-1:0]   dv;
  } row_coef_t;

  // Components: 0 bx, 1 by, 2 bz, 3 ux, 4 uy, 5 uz, 6 vx, 7 vy, 8 vz.
  // Accumulators: 0 cx, 1 cy, 2 cz, 3 ax, 4 ay, 5 az, 6 kx, 7 ky, 8 kz,
  // 9 a, 10 b, 11 c.
  function automatic step_t step_rom(input logic [STEP_W-1:0] k);
    step_t s;
    s = '0;
    unique case (k)
      5'd0:  s = '{5'd4,  4'd8,  4'd0,  1'b0, 1'b1};
      5'd1:  s = '{5'd7,  4'd5,  4'd0,  1'b1, 1'b0};
      5'd2:  s = '{5'd6,  4'd5,  4'd1,  1'b0, 1'b1};
      5'd3:  s = '{5'd3,  4'd8,  4'd1,  1'b1, 1'b0};
      5'd4:  s = '{5'd3,  4'd7,  4'd2,  1'b0, 1'b1};
      5'd5:  s = '{5'd6,  4'd4,  4'd2,  1'b1, 1'b0};
      5'd6:  s = '{5'd7,  4'd2,  4'd3,  1'b0, 1'b1};
      5'd7:  s = '{5'd1,  4'd8,  4'd3,  1'b1, 1'b0};
      5'd8:  s = '{5'd0,  4'd8,  4'd4,  1'b0, 1'b1};
      5'd9:  s = '{5'd6,  4'd2,  4'd4,  1'b1, 1'b0};
      5'd10: s = '{5'd6,  4'd1,  4'd5,  1'b0, 1'b1};
      5'd11: s = '{5'd0,  4'd7,  4'd5,  1'b1, 1'b0};
      5'd12: s = '{5'd1,  4'd5,  4'd6,  1'b0, 1'b1};
      5'd13: s = '{5'd4,  4'd2,  4'd6,  1'b1, 1'b0};
      5'd14: s = '{5'd3,  4'd2,  4'd7,  1'b0, 1'b1};
      5'd15: s = '{5'd0,  4'd5,  4'd7,  1'b1, 1'b0};
      5'd16: s = '{5'd0,  4'd4,  4'd8,  1'b0, 1'b1};
      5'd17: s = '{5'd3,  4'd1,  4'd8,  1'b1, 1'b0};
      5'd18: s = '{5'd14, 4'd9,  4'd9,  1'b0, 1'b1};
      5'd19: s = '{5'd13, 4'd10, 4'd9,  1'b0, 1'b0};
      5'd20: s = '{5'd12, 4'd11, 4'd9,  1'b0, 1'b0};
      5'd21: s = '{5'd17, 4'd9,  4'd10, 1'b0, 1'b1};
      5'd22: s = '{5'd16, 4'd10, 4'd10, 1'b0, 1'b0};
      5'd23: s = '{5'd15, 4'd11, 4'd10, 1'b0, 1'b0};
      5'd24: s = '{5'd11, 4'd9,  4'd11, 1'b0, 1'b1};
      5'd25: s = '{5'd10, 4'd10, 4'd11, 1'b0, 1'b0};
      5'd26: s = '{5'd9,  4'd11, 4'd11, 1'b0, 1'b0};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/perspective_plane_texture_mapper_top.sv
// ----------------------------------------------------------------------------
// perspective_plane_texture_mapper_top
// Perspective plane texture mapper: texel writes, row setup, pixel sampling.
// ----------------------------------------------------------------------------
// Pixel words: one per cycle unless the input is stalled; the result passes
// the store read register, then the output register. Texel write words: one
// per cycle unless stalled, no result. Start-row words: 27 multiply steps,
// each a multiply then an accumulate state, then 4 divisions in the shared
// divider, input stalled. Reset clears control state and coordinates and sets
// configuration registers to their defaults; the texture store is never cleared.
module perspective_plane_texture_mapper_top #(
  parameter int TEX_SIDE_BITS = ppm_pkg::TEX_SIDE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [15:0]                   texel_address,
  input  logic [7:0]                    texel_value,
  input  logic [7:0]                    screen_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    pixel_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppm_pkg::PADDR_W-1:0]   paddr,
  input  logic [ppm_pkg::PDATA_W-1:0]   pwdata,
  output logic [ppm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ppm_pkg::*;

  localparam int ADDR_W = 2 * TEX_SIDE_BITS;

  logic [VEC_W-1:0]    plane_origin, plane_axis_u, plane_axis_v;
  logic [9:0]          projection_distance;
  logic [9:0]          first_column_offset;
  logic [7:0]          row_centre;
  logic [23:0]         near_limit;
  logic [COORD_W-1:0]  u_coordinate, v_coordinate, u_step, v_step;
  logic                rd_pend;
  logic                out_load;
  logic                in_acc;
  logic                pix_acc;
  logic                wr_acc;
  logic                row_acc;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  row_coef_t           coef;
  logic [ADDR_W-1:0]   raddr;
  logic [7:0]          rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_origin        <= '0;
      plane_axis_u        <= '0;
      plane_axis_v        <= '0;
      projection_distance <= DIST_RST;
      first_column_offset <= COL_RST;
      row_centre          <= CENTRE_RST;
      near_limit          <= NEAR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORIGIN: plane_origin        <= pwdata[VEC_W-1:0];
        REG_AXIS_U: plane_axis_u        <= pwdata[VEC_W-1:0];
        REG_AXIS_V: plane_axis_v        <= pwdata[VEC_W-1:0];
        REG_DIST:   projection_distance <= pwdata[9:0];
        REG_COL:    first_column_offset <= pwdata[9:0];
        REG_CENTRE: row_centre          <= pwdata[7:0];
        REG_NEAR:   near_limit          <= pwdata[23:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORIGIN: prdata = PDATA_W'(plane_origin);
      REG_AXIS_U: prdata = PDATA_W'(plane_axis_u);
      REG_AXIS_V: prdata = PDATA_W'(plane_axis_v);
      REG_DIST:   prdata = PDATA_W'(projection_distance);
      REG_COL:    prdata = PDATA_W'(first_column_offset);
      REG_CENTRE: prdata = PDATA_W'(row_centre);
      REG_NEAR:   prdata = PDATA_W'(near_limit);
      default:    prdata = '0;
    endcase
  end

  // The read stage may take a new pixel only when its pending byte moves on
  // to the output register in the same cycle.
  assign out_load = rd_pend && (!out_valid || !out_stall);
  assign in_stall = coef.busy || (rd_pend && !out_load);
  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (func == FUNC_WRITE);
  assign row_acc  = in_acc && (func == FUNC_ROW);
  assign pix_acc  = in_acc && (func == FUNC_PIXEL);
  assign raddr    = {v_coordinate[16 +: TEX_SIDE_BITS], u_coordinate[16 +: TEX_SIDE_BITS]};

  ppm_row_setup u_setup (
    .clk                 (clk),
    .rst                 (rst),
    .start               (row_acc),
    .screen_row          (screen_row),
    .plane_origin        (plane_origin),
    .plane_axis_u        (plane_axis_u),
    .plane_axis_v        (plane_axis_v),
    .projection_distance (projection_distance),
    .first_column_offset (first_column_offset),
    .row_centre          (row_centre),
    .near_limit          (near_limit),
    .coef                (coef)
  );

  ppm_tex_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (ADDR_W'(texel_address)),
    .wdata (texel_value),
    .re    (pix_acc),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      u_coordinate <= '0;
      v_coordinate <= '0;
      u_step       <= '0;
      v_step       <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (coef.load) begin
        u_coordinate <= coef.u;
        v_coordinate <= coef.v;
        u_step       <= coef.du;
        v_step       <= coef.dv;
      end else if (pix_acc) begin
        u_coordinate <= u_coordinate + u_step;
        v_coordinate <= v_coordinate + v_step;
      end
      rd_pend <= pix_acc || (rd_pend && !out_load);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_value <= rdata;
    end
  end

endmodule

FILE: rtl/core/ppm_tex_store.sv
// ----------------------------------------------------------------------------
// ppm_tex_store
// Texture store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppm_tex_store #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);
  import ppm_pkg::*;

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ppm_divider.sv
// ----------------------------------------------------------------------------
// ppm_divider
// Restoring divider: trunc(num * 2^24 / den), saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module ppm_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ppm_pkg::ACC_W-1:0]  num,
  input  logic signed [ppm_pkg::ACC_W-1:0]  den,
  output logic                              done,
  output logic [ppm_pkg::COORD_W-1:0]       quot
);
  import ppm_pkg::*;

  logic                         busy;
  logic [DIV_CNT_W-1:0]         cnt;
  logic [DIV_STEPS-1:0]         nsh;
  logic [ACC_W-1:0]             rem;
  logic [ACC_W-1:0]             dmag;
  logic [COORD_W-1:0]           q;
  logic                         ovf;
  logic                         neg;
  logic [ACC_W:0]               rem_sh;
  logic                         ge;
  logic [ACC_W:0]               rem_sub;
  logic [ACC_W-1:0]             nabs;
  logic [ACC_W-1:0]             dabs;

  assign nabs    = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign dabs    = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
  assign rem_sh  = {rem, nsh[DIV_STEPS-1]};
  assign ge      = rem_sh >= {1'b0, dmag};
  assign rem_sub = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= {nabs, FRAC_BITS'(0)};
      dmag <= dabs;
      rem  <= '0;
      q    <= '0;
      ovf  <= 1'b0;
      neg  <= num[ACC_W-1] ^ den[ACC_W-1];
    end else if (busy) begin
      nsh <= {nsh[DIV_STEPS-2:0], 1'b0};
      rem <= ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      q   <= {q[COORD_W-2:0], ge};
      ovf <= ovf | q[COORD_W-1];
    end
  end

  // Positive results clamp at the largest positive value, negative ones at
  // the most negative value.
  always_comb begin
    if (!neg) begin
      quot = (ovf || q[COORD_W-1]) ? {1'b0, {(COORD_W-1){1'b1}}} : q;
    end else if (ovf || (q[COORD_W-1] && (q[COORD_W-2:0] != '0))) begin
      quot = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      quot = -q;
    end
  end

endmodule

FILE: rtl/core/ppm_row_setup.sv
// ----------------------------------------------------------------------------
// ppm_row_setup
// Row setup sequencer: forms the cross-product constants with one shared
// multiplier, then the four 16.16 coefficients with one shared divider.
// ----------------------------------------------------------------------------
module ppm_row_setup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [7:0]                    screen_row,
  input  logic [ppm_pkg::VEC_W-1:0]     plane_origin,
  input  logic [ppm_pkg::VEC_W-1:0]     plane_axis_u,
  input  logic [ppm_pkg::VEC_W-1:0]     plane_axis_v,
  input  logic [9:0]                    projection_distance,
  input  logic [9:0]                    first_column_offset,
  input  logic [7:0]                    row_centre,
  input  logic [23:0]                   near_limit,
  output ppm_pkg::row_coef_t            coef
);
  import ppm_pkg::*;

  setup_state_t              state, state_next;
  logic [STEP_W-1:0]         step;
  logic [1:0]                div_idx;
  logic [7:0]                row;
  step_t                     cur;
  logic signed [15:0]        comp [NUM_COMP];
  logic signed [ACC_W-1:0]   acc [NUM_ACC];
  logic signed [ACC_W-1:0]   run;
  logic signed [ACC_W-1:0]   run_next;
  logic signed [ACC_W-1:0]   prod;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [ACC_W:0]     prod_full;
  logic [4:0]                a_off;
  logic signed [8:0]         dy;
  logic signed [ACC_W-1:0]   den;
  logic signed [ACC_W-1:0]   den_next;
  logic [ACC_W-1:0]          c_mag;
  logic [ACC_W-1:0]          lim;
  logic signed [ACC_W-1:0]   div_num;
  logic                      div_done;
  logic [COORD_W-1:0]        div_quot;
  logic [COORD_W-1:0]        res [4];
  logic                      mul_en, acc_en, den_en, div_go;

  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign comp[k]     = plane_origin[16*k +: 16];
    assign comp[k + 3] = plane_axis_u[16*k +: 16];
    assign comp[k + 6] = plane_axis_v[16*k +: 16];
  end

  assign cur   = step_rom(step);
  assign a_off = cur.a_sel - 5'd9;
  assign dy    = $signed({1'b0, row}) - $signed({1'b0, row_centre});

  always_comb begin
    if (cur.a_sel < 5'd9) begin
      op_a = OPA_W'(comp[cur.a_sel[3:0]]);
    end else begin
      op_a = acc[a_off[3:0]][OPA_W-1:0];
    end
    priority case (1'b1)
      cur.b_sel == 4'd9:  op_b = $signed({6'b0, projection_distance});
      cur.b_sel == 4'd10: op_b = OPB_W'(dy);
      cur.b_sel == 4'd11: op_b = OPB_W'($signed(first_column_offset));
      default:            op_b = comp[cur.b_sel];
    endcase
  end

  assign prod_full = op_a * op_b;

  always_comb begin
    if (cur.first) begin
      run_next = cur.sub ? -prod : prod;
    end else begin
      run_next = cur.sub ? run - prod : run + prod;
    end
  end

  // A near limit of zero acts as one; the limit is compared in Q.8 units.
  assign lim      = ACC_W'({(near_limit == '0) ? 24'd1 : near_limit, 8'd0});
  assign c_mag    = acc[11][ACC_W-1] ? ACC_W'(-acc[11]) : ACC_W'(acc[11]);
  assign den_next = (c_mag > lim) ? acc[11] : $signed(lim);

  always_comb begin
    unique case (div_idx)
      2'd0: div_num = acc[9];
      2'd1: div_num = acc[10];
      2'd2: div_num = acc[3];
      2'd3: div_num = acc[6];
    endcase
  end

  ppm_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (start) state_next = S_MUL;
      S_MUL:      state_next = S_ACC;
      S_ACC:      state_next = (step == STEP_W'(NUM_STEPS - 1)) ? S_DEN : S_MUL;
      S_DEN:      state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) state_next = (div_idx == 2'd3) ? S_DONE : S_DIV_GO;
      end
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_en    = state == S_MUL;
    acc_en    = state == S_ACC;
    den_en    = state == S_DEN;
    div_go    = state == S_DIV_GO;
    coef.busy = state != S_IDLE;
    coef.load = state == S_DONE;
    coef.u    = res[0];
    coef.v    = res[1];
    coef.du   = res[2];
    coef.dv   = res[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      div_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        step    <= '0;
        div_idx <= '0;
      end else if (acc_en) begin
        step <= step + STEP_W'(1);
      end else if (state == S_DIV_WAIT && div_done) begin
        div_idx <= div_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      row <= screen_row;
    end
    if (mul_en) begin
      prod <= prod_full[ACC_W-1:0];
    end
    if (acc_en) begin
      run           <= run_next;
      acc[cur.dest] <= run_next;
    end
    if (den_en) begin
      den <= den_next;
    end
    if (state == S_DIV_WAIT && div_done) begin
      res[div_idx] <= div_quot;
    end
  end

endmodule

FILE: rtl/core/ppm_checker.sv
// ----------------------------------------------------------------------------
// ppm_checker
// Port-level checks of the texture mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ppm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_value
);
  import ppm_pkg::*;

  // A result word waiting on a stall stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_value))
    else $error("stalled result word changed");

  // Row setup holds the input off in the cycle after a start-row word.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_ROW) |=> in_stall)
    else $error("input taken during row setup");

  // Only pixel words produce results, so none can appear right after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind perspective_plane_texture_mapper_top ppm_checker u_ppm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .func        (func),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_value (pixel_value)
);
